FILE: design/udp_arp_receive_filter_defines.svh
// Assertion helpers shared by the filter RTL.
`ifndef UDP_ARP_RECEIVE_FILTER_DEFINES_SVH
`define UDP_ARP_RECEIVE_FILTER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define UARF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("udp_arp_receive_filter: check failed");

// Next-cycle implication, checked out of reset.
`define UARF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("udp_arp_receive_filter: check failed");

`endif

FILE: design/uarf_pkg.sv
package uarf_pkg;

  // Frame size limit and derived widths
  localparam int MaxFrame = 2048;
  localparam int PosW     = $clog2(MaxFrame);
  localparam int LenW     = PosW + 1;

  localparam int EthHdr    = 14;
  localparam int ArpMinLen = 42;
  localparam int UdpHdr    = 8;

  localparam logic [15:0] EthPIp   = 16'h0800;
  localparam logic [15:0] EthPArp  = 16'h0806;
  localparam logic [7:0]  IpprotoUdp = 8'd17;
  localparam logic [7:0]  ArpopRequest = 8'd1;
  localparam logic [7:0]  ArphrdEther = 8'd1;
  localparam logic [7:0]  ArphrdIeee802 = 8'd6;
  localparam logic [31:0] IpBroadcast = 32'hffff_ffff;

  // Configuration register indexes
  localparam int CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CfgLocalIp    = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgLocalPort  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgLocalMac   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgAcceptBcast = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgDropAll    = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgAnswerArp  = 3'd5;

  typedef enum logic [1:0] {
    VerdictNone = 2'd0,
    VerdictUdp  = 2'd1,
    VerdictArp  = 2'd2
  } verdict_e;

  typedef struct packed {
    logic [31:0] own_ip;
    logic [15:0] own_port;
    logic [47:0] local_mac;
    logic        accept_bcast;
    logic        drop_all;
    logic        answer_arp;
  } cfg_t;

  // Header fields captured while a frame streams past
  typedef struct packed {
    logic [47:0] dest_mac;
    logic [47:0] src_mac;
    logic [15:0] ether_type;
    logic [3:0]  hdr_words;
    logic [3:0]  version;
    logic [15:0] ip_total;
    logic [16:0] csum;
    logic [7:0]  protocol;
    logic [31:0] ip_src;
    logic [31:0] ip_dst;
    logic [15:0] udp_src;
    logic [15:0] udp_dst;
    logic [15:0] udp_len;
    logic        arp_ok;
    logic [47:0] arp_smac;
    logic [31:0] arp_sip;
    logic [31:0] arp_tip;
  } frame_t;

  // Everything the classifier needs at the end of a frame
  typedef struct packed {
    frame_t          f;
    logic            too_long;
    logic [LenW-1:0] len;
  } snap_t;

  typedef struct packed {
    verdict_e    verdict;
    logic        drop_frame;
    logic [15:0] peer_port;
    logic [31:0] peer_ip;
    logic [47:0] peer_mac;
    logic [10:0] payload_offset;
    logic [10:0] payload_length;
  } result_t;

endpackage

FILE: design/uarf_if.sv
interface uarf_frame_if import uarf_pkg::*;;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_end;
  modport source (output valid, frame_byte, frame_end, input ready);
  modport sink (input valid, frame_byte, frame_end, output ready);
endinterface

interface uarf_result_if import uarf_pkg::*;;
  logic        valid;
  logic        ready;
  logic [1:0]  verdict;
  logic        drop_frame;
  logic [15:0] peer_port;
  logic [31:0] peer_ip;
  logic [47:0] peer_mac;
  logic [10:0] payload_offset;
  logic [10:0] payload_length;
  modport source (output valid, verdict, drop_frame, peer_port, peer_ip, peer_mac,
                  payload_offset, payload_length, input ready);
  modport sink (input valid, verdict, drop_frame, peer_port, peer_ip, peer_mac,
                payload_offset, payload_length, output ready);
endinterface

interface uarf_cfg_if import uarf_pkg::*;;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [47:0]        data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: design/uarf_parser.sv
module uarf_parser import uarf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       advance_i,
  input  logic       byte_valid_i,
  input  logic [7:0] byte_i,
  input  logic       end_i,
  output logic       snap_valid_o,
  output snap_t      snap_o
);

  logic [PosW-1:0] pos_q;
  logic            too_long_q;
  frame_t          fr_q, fr_d;
  logic            snap_valid_q;
  snap_t           snap_q;

  logic [PosW-1:0] r, u, hl;
  logic [3:0]      hw;
  logic [16:0]     sum;

  // Capture of the current byte into the header fields
  always_comb begin
    fr_d = fr_q;
    r    = pos_q - PosW'(EthHdr);
    hw   = (r == '0) ? byte_i[3:0] : fr_q.hdr_words;
    hl   = PosW'({hw, 2'b00});
    u    = r - hl;
    sum  = fr_q.csum + (r[0] ? {9'b0, byte_i} : {1'b0, byte_i, 8'b0});
    if (sum[16]) begin
      sum = {1'b0, sum[15:0]} + 17'd1;
    end
    if (!too_long_q) begin
      if (pos_q < PosW'(6)) begin
        fr_d.dest_mac = {fr_q.dest_mac[39:0], byte_i};
      end else if (pos_q < PosW'(12)) begin
        fr_d.src_mac = {fr_q.src_mac[39:0], byte_i};
      end else if (pos_q < PosW'(EthHdr)) begin
        fr_d.ether_type = {fr_q.ether_type[7:0], byte_i};
      end else begin
        if (r == '0) begin
          fr_d.version   = byte_i[7:4];
          fr_d.hdr_words = byte_i[3:0];
        end
        if (r < hl) begin
          fr_d.csum = sum;
        end
        if (r == PosW'(2) || r == PosW'(3)) begin
          fr_d.ip_total = {fr_q.ip_total[7:0], byte_i};
        end
        if (r == PosW'(9)) begin
          fr_d.protocol = byte_i;
        end
        if (r >= PosW'(12) && r < PosW'(16)) begin
          fr_d.ip_src = {fr_q.ip_src[23:0], byte_i};
        end
        if (r >= PosW'(16) && r < PosW'(20)) begin
          fr_d.ip_dst = {fr_q.ip_dst[23:0], byte_i};
        end
        // UDP header sits right after the IP options
        if (r >= hl) begin
          if (u < PosW'(2)) begin
            fr_d.udp_src = {fr_q.udp_src[7:0], byte_i};
          end else if (u < PosW'(4)) begin
            fr_d.udp_dst = {fr_q.udp_dst[7:0], byte_i};
          end else if (u < PosW'(6)) begin
            fr_d.udp_len = {fr_q.udp_len[7:0], byte_i};
          end
        end
        // ARP fixed header checks
        if (r == PosW'(0)) begin
          fr_d.arp_ok = (byte_i == 8'h00);
        end else if (r == PosW'(1)) begin
          fr_d.arp_ok = fr_q.arp_ok && (byte_i == ArphrdEther || byte_i == ArphrdIeee802);
        end else if (r == PosW'(2)) begin
          fr_d.arp_ok = fr_q.arp_ok && (byte_i == EthPIp[15:8]);
        end else if (r == PosW'(3) || r == PosW'(6)) begin
          fr_d.arp_ok = fr_q.arp_ok && (byte_i == 8'h00);
        end else if (r == PosW'(7)) begin
          fr_d.arp_ok = fr_q.arp_ok && (byte_i == ArpopRequest);
        end
        if (r >= PosW'(8) && r < PosW'(14)) begin
          fr_d.arp_smac = {fr_q.arp_smac[39:0], byte_i};
        end
        if (r >= PosW'(14) && r < PosW'(18)) begin
          fr_d.arp_sip = {fr_q.arp_sip[23:0], byte_i};
        end
        if (r >= PosW'(24) && r < PosW'(28)) begin
          fr_d.arp_tip = {fr_q.arp_tip[23:0], byte_i};
        end
      end
    end
  end

  // Per-frame state and end-of-frame snapshot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      too_long_q   <= 1'b0;
      fr_q         <= '0;
      snap_valid_q <= 1'b0;
    end else if (advance_i) begin
      snap_valid_q <= byte_valid_i && end_i;
      if (byte_valid_i) begin
        if (end_i) begin
          pos_q      <= '0;
          too_long_q <= 1'b0;
          fr_q       <= '0;
        end else begin
          fr_q <= fr_d;
          if (!too_long_q) begin
            if (pos_q == PosW'(MaxFrame - 1)) begin
              too_long_q <= 1'b1;
            end else begin
              pos_q <= pos_q + PosW'(1);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i && byte_valid_i && end_i) begin
      snap_q.f        <= fr_d;
      snap_q.too_long <= too_long_q;
      snap_q.len      <= {1'b0, pos_q} + LenW'(1);
    end
  end

  assign snap_valid_o = snap_valid_q;
  assign snap_o       = snap_q;

endmodule

FILE: design/uarf_classifier.sv
module uarf_classifier import uarf_pkg::*; (
  input  snap_t   snap_i,
  input  cfg_t    cfg_i,
  output result_t res_o
);

  frame_t      f;
  logic [5:0]  hl;
  logic        otherhost, len_ok, udp_ok, port_match, ip_match, arp_frame, arp_hit;
  logic [15:0] plen_full;

  assign f = snap_i.f;
  assign hl = {f.hdr_words, 2'b00};

  // Destination must be a group address or ours
  assign otherhost = !f.dest_mac[40] && (f.dest_mac != cfg_i.local_mac);
  assign len_ok = (17'(f.ip_total) + 17'(EthHdr)) <= 17'(snap_i.len);

  assign udp_ok = !snap_i.too_long && (f.ether_type == EthPIp) && !otherhost &&
                  (f.version == 4'd4) && (f.hdr_words >= 4'd5) &&
                  (f.csum == 17'h0ffff) && len_ok && (f.ip_total >= 16'(hl)) &&
                  (f.protocol == IpprotoUdp) &&
                  (f.udp_len == f.ip_total - 16'(hl)) && (f.udp_len >= 16'(UdpHdr));
  assign port_match = (cfg_i.own_port != '0) && (f.udp_dst == cfg_i.own_port);
  assign ip_match   = (cfg_i.own_ip != '0) && (f.ip_dst == cfg_i.own_ip);

  // ARP request aimed at our unicast address
  assign arp_frame = cfg_i.answer_arp && (f.ether_type == EthPArp);
  assign arp_hit = !snap_i.too_long && (snap_i.len >= LenW'(ArpMinLen)) && f.arp_ok &&
                   (f.arp_tip[31:24] != 8'd127) && (f.arp_tip[31:28] != 4'he) &&
                   (f.arp_tip == cfg_i.own_ip);

  assign plen_full = f.udp_len - 16'(UdpHdr);

  always_comb begin
    res_o = '0;
    res_o.verdict = VerdictNone;
    if (arp_frame) begin
      if (arp_hit) begin
        res_o.verdict  = VerdictArp;
        res_o.peer_ip  = f.arp_sip;
        res_o.peer_mac = f.arp_smac;
      end
    end else if (udp_ok && port_match &&
                 (ip_match || (cfg_i.accept_bcast && f.ip_dst == IpBroadcast))) begin
      res_o.verdict        = VerdictUdp;
      res_o.peer_port      = f.udp_src;
      res_o.peer_ip        = f.ip_src;
      res_o.peer_mac       = f.src_mac;
      res_o.payload_offset = 11'(EthHdr) + 11'(hl) + 11'(UdpHdr);
      res_o.payload_length = plen_full[10:0];
    end
    res_o.drop_frame = cfg_i.drop_all || (udp_ok && port_match && ip_match);
  end

endmodule

FILE: design/udp_arp_receive_filter.sv
// A frame's verdict follows its last byte through the parser snapshot and the output register.
// Throughput: one byte per cycle while the result side takes results; a stalled
// result holds the whole pipe (input register, parser, output register).
// Reset: asynchronous, active low; clears parser state, configuration
// registers and all valid flags. No clearing pass is needed.
`include "udp_arp_receive_filter_defines.svh"

module udp_arp_receive_filter import uarf_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  uarf_frame_if.sink   frame_i,
  uarf_cfg_if.sink     cfg_i,
  uarf_result_if.source result_o
);

  logic       advance;
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_end_q;
  cfg_t       cfg_q;
  logic       snap_valid;
  snap_t      snap;
  result_t    res, res_q;
  logic       out_valid_q;

  assign advance       = !out_valid_q || result_o.ready;
  assign frame_i.ready = advance;
  assign cfg_i.ready   = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CfgLocalIp:     cfg_q.own_ip       <= cfg_i.data[31:0];
        CfgLocalPort:   cfg_q.own_port     <= cfg_i.data[15:0];
        CfgLocalMac:    cfg_q.local_mac    <= cfg_i.data;
        CfgAcceptBcast: cfg_q.accept_bcast <= cfg_i.data[0];
        CfgDropAll:     cfg_q.drop_all     <= cfg_i.data[0];
        CfgAnswerArp:   cfg_q.answer_arp   <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (advance) begin
      in_valid_q <= frame_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      in_byte_q <= frame_i.frame_byte;
      in_end_q  <= frame_i.frame_end;
    end
  end

  uarf_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .advance_i    (advance),
    .byte_valid_i (in_valid_q),
    .byte_i       (in_byte_q),
    .end_i        (in_end_q),
    .snap_valid_o (snap_valid),
    .snap_o       (snap)
  );

  uarf_classifier u_classifier (
    .snap_i (snap),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= snap_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && snap_valid) begin
      res_q <= res;
    end
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.verdict        = res_q.verdict;
  assign result_o.drop_frame     = res_q.drop_frame;
  assign result_o.peer_port      = res_q.peer_port;
  assign result_o.peer_ip        = res_q.peer_ip;
  assign result_o.peer_mac       = res_q.peer_mac;
  assign result_o.payload_offset = res_q.payload_offset;
  assign result_o.payload_length = res_q.payload_length;

  // Only last bytes produce results; each goes from the input register to the snapshot and on to the output register
  `UARF_ASSERT_NXT(a_end_to_snap, advance && in_valid_q && in_end_q, snap_valid)
  `UARF_ASSERT_NXT(a_snap_to_out, advance && snap_valid, out_valid_q)
  // A drop without drop_all needs a delivered datagram
  `UARF_ASSERT_IMP(a_drop_udp, out_valid_q && res_q.drop_frame && !cfg_q.drop_all,
                   res_q.verdict == VerdictUdp)
  // Ignored frames carry no UDP details
  `UARF_ASSERT_IMP(a_none_clear, out_valid_q && res_q.verdict == VerdictNone,
                   res_q.peer_port == '0 && res_q.payload_offset == '0)

endmodule
